>>> design/bucketed_hash_set_unit_assert.svh
// Assertion macros for the bucketed hash set RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef BUCKETED_HASH_SET_UNIT_ASSERT_SVH
`define BUCKETED_HASH_SET_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define BHS_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define BHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BHS_ASSERT(label, clk, rst_n, expr, msg)

`define BHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/bhs_pkg.sv
// Shared constants, codes and types of the bucketed hash set.
// Depends on nothing; every other design module refers to it by scoped names.
package bhs_pkg;

    // Geometry of the store. The bucket count is a power of two, so the
    // bucket of a key is its low bits.
    localparam int NUM_BUCKETS      = 16;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam int KEY_W        = 31;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int BUCKET_OUT_W = 4;
    localparam int SLOT_OUT_W   = 2;

    localparam int BKT_IDX_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOT_IDX_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

    // Request encodings on the func port.
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;

    // Internal operation codes after classification.
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [KEY_W-1:0]     key;
        logic [BKT_IDX_W-1:0] bucket;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] key_row_t;

endpackage

>>> design/bhs_front.sv
// Front end of the bucketed hash set: accepts request beats and classifies them.
// Depends on bhs_pkg; feeds bhs_queue.
module bhs_front
(
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [bhs_pkg::FUNC_W-1:0] func,
    input  logic [bhs_pkg::KEY_W-1:0]  key,
    input  bhs_pkg::q_status_t         q_status,
    output logic                       push,
    output bhs_pkg::q_entry_t          push_entry
);

    logic [1:0] op;

    // The spare selector behaves as a find.
    always_comb
    begin
        unique case (func)
            bhs_pkg::FUNC_INSERT: op = bhs_pkg::OP_INSERT;
            bhs_pkg::FUNC_DELETE: op = bhs_pkg::OP_DELETE;
            bhs_pkg::FUNC_FIND,
            bhs_pkg::FUNC_SPARE:  op = bhs_pkg::OP_FIND;
            default:              op = bhs_pkg::OP_FIND;
        endcase
    end

    assign req_stall         = q_status.full;
    assign push              = req_valid && !q_status.full;
    assign push_entry.op     = op;
    assign push_entry.key    = key;
    assign push_entry.bucket = key[bhs_pkg::BKT_IDX_W-1:0];

endmodule

>>> design/bhs_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on bhs_pkg for the entry type and depth.
module bhs_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bhs_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output bhs_pkg::q_entry_t  pop_entry,
    output bhs_pkg::q_status_t q_status
);

    localparam int PTR_W = (bhs_pkg::QUEUE_DEPTH > 1) ? $clog2(bhs_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bhs_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bhs_pkg::QUEUE_DEPTH - 1);

    bhs_pkg::q_entry_t entry_reg [bhs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry      = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(bhs_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

>>> design/bhs_back.sv
// Back end of the bucketed hash set: row read, slot compare, write-back, result register.
// Depends on bhs_pkg and the assertion macros; drains bhs_queue.
`include "bucketed_hash_set_unit_assert.svh"

module bhs_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  bhs_pkg::q_status_t                q_status,
    input  bhs_pkg::q_entry_t                 pop_entry,
    output logic                              pop,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [bhs_pkg::STATUS_W-1:0]      status,
    output logic [bhs_pkg::BUCKET_OUT_W-1:0]  bucket,
    output logic [bhs_pkg::SLOT_OUT_W-1:0]    slot
);

    localparam int SLOTS = bhs_pkg::SLOTS_PER_BUCKET;
    localparam int SW    = bhs_pkg::SLOT_IDX_W;

    localparam logic S_READ = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;

    // Key store: one row per bucket, read and written a whole row at a time.
    bhs_pkg::key_row_t key_mem [bhs_pkg::NUM_BUCKETS];
    bhs_pkg::key_row_t row_reg;
    bhs_pkg::key_row_t row_wr;

    logic [bhs_pkg::NUM_BUCKETS-1:0][SLOTS-1:0] valid_reg, valid_next;

    logic [1:0]                    op_reg;
    logic [bhs_pkg::KEY_W-1:0]     key_reg;
    logic [bhs_pkg::BKT_IDX_W-1:0] bkt_reg;

    logic                              out_valid_reg, out_valid_next;
    logic [bhs_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [bhs_pkg::BUCKET_OUT_W-1:0]  bucket_reg;
    logic [bhs_pkg::SLOT_OUT_W-1:0]    slot_reg, slot_next;

    logic [SLOTS-1:0] row_valid;
    logic [SLOTS-1:0] match;
    logic             hit, has_free;
    logic [SW-1:0]    hit_slot, free_slot;
    logic             exec, mem_wr, ins_ok, del_ok, rsp_take;

    assign rsp_take  = out_valid_reg && !rsp_stall;
    // Pop only when the result register is free by the time this item finishes.
    assign pop       = (state_reg == S_READ) && !q_status.empty && (!out_valid_reg || !rsp_stall);
    assign exec      = (state_reg == S_EXEC);
    assign row_valid = valid_reg[bkt_reg];

    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        has_free  = 1'b0;
        free_slot = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            match[s] = row_valid[s] && (row_reg[s] == key_reg);
        end
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (match[s])
            begin
                hit      = 1'b1;
                hit_slot = SW'(s);
            end
            if (!row_valid[s])
            begin
                has_free  = 1'b1;
                free_slot = SW'(s);
            end
        end
    end

    always_comb
    begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        status_next = bhs_pkg::ST_NOT_FOUND;
        slot_next   = '0;
        unique case (op_reg)
            bhs_pkg::OP_INSERT:
            begin
                if (hit)
                begin
                    status_next = bhs_pkg::ST_PRESENT;
                    slot_next   = bhs_pkg::SLOT_OUT_W'(hit_slot);
                end
                else if (has_free)
                begin
                    ins_ok      = 1'b1;
                    status_next = bhs_pkg::ST_DONE;
                    slot_next   = bhs_pkg::SLOT_OUT_W'(free_slot);
                end
                else
                begin
                    status_next = bhs_pkg::ST_FULL;
                end
            end
            bhs_pkg::OP_DELETE:
            begin
                if (hit)
                begin
                    del_ok      = 1'b1;
                    status_next = bhs_pkg::ST_DONE;
                    slot_next   = bhs_pkg::SLOT_OUT_W'(hit_slot);
                end
            end
            default:
            begin
                if (hit)
                begin
                    status_next = bhs_pkg::ST_DONE;
                    slot_next   = bhs_pkg::SLOT_OUT_W'(hit_slot);
                end
            end
        endcase
    end

    assign mem_wr = exec && ins_ok;

    always_comb
    begin
        row_wr            = row_reg;
        row_wr[free_slot] = key_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (exec && ins_ok)
        begin
            valid_next[bkt_reg][free_slot] = 1'b1;
        end
        else if (exec && del_ok)
        begin
            valid_next[bkt_reg][hit_slot] = 1'b0;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_READ:  state_next = pop ? S_EXEC : S_READ;
            S_EXEC:  state_next = S_READ;
            default: state_next = S_READ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READ;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            row_reg <= key_mem[pop_entry.bucket];
            op_reg  <= pop_entry.op;
            key_reg <= pop_entry.key;
            bkt_reg <= pop_entry.bucket;
        end
        if (mem_wr)
        begin
            key_mem[bkt_reg] <= row_wr;
        end
        if (exec)
        begin
            status_reg <= status_next;
            bucket_reg <= bhs_pkg::BUCKET_OUT_W'(bkt_reg);
            slot_reg   <= slot_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = status_reg;
    assign bucket    = bucket_reg;
    assign slot      = slot_reg;

    `BHS_ASSERT(a_exec_out_free, clk, rst_n, !exec || !out_valid_reg,
        "result register busy while executing")
    `BHS_ASSERT_NEXT(a_insert_sets_one, clk, rst_n, exec && ins_ok,
        $countones(valid_reg) == $past($countones(valid_reg)) + 1,
        "insert did not set exactly one valid bit")
    `BHS_ASSERT_NEXT(a_delete_clears_one, clk, rst_n, exec && del_ok,
        $countones(valid_reg) + 1 == $past($countones(valid_reg)),
        "delete did not clear exactly one valid bit")

endmodule

>>> design/bucketed_hash_set_unit.sv
// Top level of the bucketed hash set unit.
// Depends on bhs_pkg, bhs_front, bhs_queue and bhs_back.
//
// The unit keeps a set of 31-bit keys in 16 buckets of 4 slots; a key lives in
// the bucket given by its low four bits. Each request beat (func, key) asks to
// find, insert or delete a key, and produces exactly one response beat (status,
// bucket, slot) in request order. Status 0 means done or found, 1 not found,
// 2 already present (insert of a key that is in the set, slot tells where), and
// 3 bucket full (insert with no free slot). Insert takes the lowest free slot.
// The spare func code behaves as a find. Both channels use valid and stall; a
// beat moves on a rising edge with valid high and stall low. The front end
// decodes requests into a two-entry queue, so it keeps taking beats while the
// back end works or while a finished response waits. The back end steps each
// item through two states: S_READ reads the bucket's row from the key-store
// memory, and S_EXEC compares all slots in parallel and writes the row back.
// It takes no new item until the last has left S_EXEC, nor while a waiting
// response is still stalled. Slot valid bits live in flip-flops that reset
// clears at once, so there is no clearing pass after reset.
module bucketed_hash_set_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [bhs_pkg::FUNC_W-1:0]        func,
    input  logic [bhs_pkg::KEY_W-1:0]         key,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [bhs_pkg::STATUS_W-1:0]      status,
    output logic [bhs_pkg::BUCKET_OUT_W-1:0]  bucket,
    output logic [bhs_pkg::SLOT_OUT_W-1:0]    slot
);

    // Queue handshake between the two halves.
    logic               push;
    logic               pop;
    bhs_pkg::q_entry_t  push_entry;
    bhs_pkg::q_entry_t  pop_entry;
    bhs_pkg::q_status_t q_status;

    // The front end only decodes and stalls when the queue is full.
    bhs_front u_front
    (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .key        (key),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Two entries let the front end keep taking beats while the back end works on an item.
    bhs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    // The back end owns the key store, the valid bits and the response register.
    bhs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .bucket    (bucket),
        .slot      (slot)
    );

endmodule

>>> bench/bucketed_hash_set_checker.sv
`timescale 1ns / 1ps
// Checker for the bucketed hash set unit: watches both channels and keeps its own copy of the set.
// It predicts each response and compares it field by field. Depends on bhs_pkg.
module bucketed_hash_set_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  logic [bhs_pkg::FUNC_W-1:0]       func,
    input  logic [bhs_pkg::KEY_W-1:0]        key,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  logic [bhs_pkg::STATUS_W-1:0]     status,
    input  logic [bhs_pkg::BUCKET_OUT_W-1:0] bucket,
    input  logic [bhs_pkg::SLOT_OUT_W-1:0]   slot,
    output int                               failures,
    output int                               pending
);

    localparam int ENTRIES = bhs_pkg::NUM_BUCKETS * bhs_pkg::SLOTS_PER_BUCKET;

    typedef struct packed {
        logic [bhs_pkg::STATUS_W-1:0]     status;
        logic [bhs_pkg::BUCKET_OUT_W-1:0] bucket;
        logic [bhs_pkg::SLOT_OUT_W-1:0]   slot;
    } set_response_t;

    logic [bhs_pkg::KEY_W-1:0] stored_key [ENTRIES];
    bit                        entry_used [ENTRIES];
    set_response_t             owed_responses [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        failures++;
    endtask

    // Applies one request to the shadow set and returns the response it owes.
    function automatic set_response_t set_operation(input logic [bhs_pkg::FUNC_W-1:0] op,
                                                    input logic [bhs_pkg::KEY_W-1:0] k);
        set_response_t r;
        int            row;
        int            hit;
        int            free_slot;
        row       = int'(k % bhs_pkg::NUM_BUCKETS) * bhs_pkg::SLOTS_PER_BUCKET;
        hit       = -1;
        free_slot = -1;
        // Scan downward so that the lowest matching and lowest free slots win.
        for (int s = bhs_pkg::SLOTS_PER_BUCKET - 1; s >= 0; s--)
        begin
            if (entry_used[row + s] && stored_key[row + s] == k)
                hit = s;
            if (!entry_used[row + s])
                free_slot = s;
        end
        r.bucket = bhs_pkg::BUCKET_OUT_W'(k % bhs_pkg::NUM_BUCKETS);
        r.slot   = '0;
        r.status = bhs_pkg::ST_NOT_FOUND;
        if (op == bhs_pkg::FUNC_INSERT)
        begin
            if (hit >= 0)
            begin
                r.status = bhs_pkg::ST_PRESENT;
                r.slot   = bhs_pkg::SLOT_OUT_W'(hit);
            end
            else if (free_slot >= 0)
            begin
                stored_key[row + free_slot] = k;
                entry_used[row + free_slot] = 1'b1;
                r.status = bhs_pkg::ST_DONE;
                r.slot   = bhs_pkg::SLOT_OUT_W'(free_slot);
            end
            else
            begin
                r.status = bhs_pkg::ST_FULL;
            end
        end
        else if (op == bhs_pkg::FUNC_DELETE)
        begin
            if (hit >= 0)
            begin
                entry_used[row + hit] = 1'b0;
                r.status = bhs_pkg::ST_DONE;
                r.slot   = bhs_pkg::SLOT_OUT_W'(hit);
            end
        end
        else if (hit >= 0)
        begin
            // Find, and the spare code that behaves as a find.
            r.status = bhs_pkg::ST_DONE;
            r.slot   = bhs_pkg::SLOT_OUT_W'(hit);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_response_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                entry_used[i] = 1'b0;
            owed_responses.delete();
            failures = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_responses.size() == 0)
                begin
                    report_mismatch("response beat with nothing owed", 1, 0);
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (bucket !== want.bucket)
                        report_mismatch("bucket", bucket, want.bucket);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                end
            end
            if (req_valid && !req_stall)
                owed_responses.push_back(set_operation(func, key));
        end
        pending <= owed_responses.size();
    end

endmodule

>>> bench/bucketed_hash_set_unit_tb.sv
`timescale 1ns / 1ps
// Top of the bucketed hash set unit bench: clock, reset, request and response drivers, verdict.
// Depends on bhs_pkg, the unit itself and bucketed_hash_set_checker.
module bucketed_hash_set_unit_tb;

    // Number of random request beats in each idling phase, and in the phase
    // where the response side holds off for a long stretch.
    localparam int PHASE_BEATS    = 480;
    localparam int PRESSURE_BEATS = 100;
    localparam int HOLD_CYCLES    = 200;
    localparam int KEY_POOL_SIZE  = 128;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             req_valid;
    logic                             req_stall;
    logic [bhs_pkg::FUNC_W-1:0]       func;
    logic [bhs_pkg::KEY_W-1:0]        key;
    logic                             rsp_valid;
    logic                             rsp_stall;
    logic [bhs_pkg::STATUS_W-1:0]     status;
    logic [bhs_pkg::BUCKET_OUT_W-1:0] bucket;
    logic [bhs_pkg::SLOT_OUT_W-1:0]   slot;

    int failures;
    int pending;

    // Percentages of cycles in which the request side sits idle and the
    // response side stalls. The stimulus process changes them per phase.
    int req_idle_pct = 0;
    int rsp_idle_pct = 0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    logic [bhs_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    bucketed_hash_set_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .bucket    (bucket),
        .slot      (slot)
    );

    bucketed_hash_set_checker i_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .bucket    (bucket),
        .slot      (slot),
        .failures  (failures),
        .pending   (pending)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop. The slowest correct run, about 2000 beats plus the long
    // hold-off, ends well before this.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Response side. It stalls at random at the rate of the current phase.
    // When the stimulus asks for it, it holds stall high for a long run of
    // cycles so that the unit's queue fills and the request side backs up.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= (rsp_idle_pct > 0) && ($urandom_range(0, 99) < rsp_idle_pct);
            end
        end
    end

    // Offers one request beat. It is called at a falling edge and returns at
    // the falling edge after the beat was taken. Any idle cycles are decided
    // before valid rises, so valid never depends on stall, and the payload
    // stays put while the beat is stalled.
    task automatic send_request(input logic [bhs_pkg::FUNC_W-1:0] op,
                                input logic [bhs_pkg::KEY_W-1:0] k);
        while (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        func      <= op;
        key       <= k;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // A random request beat. Most keys come from a pool with eight keys per
    // bucket, so buckets fill up, keys are found and deleted again, and
    // inserts of present keys happen often. The rest are fully random keys.
    task automatic send_random_request();
        int                         pick;
        logic [bhs_pkg::FUNC_W-1:0] op;
        logic [bhs_pkg::KEY_W-1:0]  k;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = bhs_pkg::FUNC_INSERT;
        else if (pick < 65)
            op = bhs_pkg::FUNC_DELETE;
        else if (pick < 95)
            op = bhs_pkg::FUNC_FIND;
        else
            op = bhs_pkg::FUNC_SPARE;
        if ($urandom_range(0, 9) < 8)
            k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else
            k = bhs_pkg::KEY_W'($urandom);
        send_request(op, k);
    endtask

    task automatic run_phase(input int req_pct, input int rsp_pct, input int beats);
        req_idle_pct = req_pct;
        rsp_idle_pct = rsp_pct;
        repeat (beats) send_random_request();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        func      = bhs_pkg::FUNC_FIND;
        key       = '0;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = {27'($urandom), 4'(i % bhs_pkg::NUM_BUCKETS)};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Bucket 0 is filled to the brim with keys 0, 16, 32
        // and 48, then a fifth key is refused as full. A delete frees slot 1,
        // which the next insert takes as the lowest free slot. The largest
        // key and alternating bit patterns cover the edges of the key field.
        send_request(bhs_pkg::FUNC_FIND,   31'd0);
        send_request(bhs_pkg::FUNC_DELETE, 31'd0);
        send_request(bhs_pkg::FUNC_INSERT, 31'd0);
        send_request(bhs_pkg::FUNC_INSERT, 31'd0);
        send_request(bhs_pkg::FUNC_INSERT, 31'd16);
        send_request(bhs_pkg::FUNC_INSERT, 31'd32);
        send_request(bhs_pkg::FUNC_INSERT, 31'd48);
        send_request(bhs_pkg::FUNC_INSERT, 31'd64);
        send_request(bhs_pkg::FUNC_FIND,   31'd32);
        send_request(bhs_pkg::FUNC_SPARE,  31'd48);
        send_request(bhs_pkg::FUNC_SPARE,  31'd64);
        send_request(bhs_pkg::FUNC_DELETE, 31'd16);
        send_request(bhs_pkg::FUNC_FIND,   31'd16);
        send_request(bhs_pkg::FUNC_INSERT, 31'd64);
        send_request(bhs_pkg::FUNC_INSERT, 31'h7FFF_FFFF);
        send_request(bhs_pkg::FUNC_FIND,   31'h7FFF_FFFF);
        send_request(bhs_pkg::FUNC_INSERT, 31'h7FFF_FFEF);
        send_request(bhs_pkg::FUNC_DELETE, 31'h7FFF_FFFF);
        send_request(bhs_pkg::FUNC_FIND,   31'h7FFF_FFEF);
        send_request(bhs_pkg::FUNC_INSERT, 31'h5555_5555);
        send_request(bhs_pkg::FUNC_INSERT, 31'h2AAA_AAAA);
        send_request(bhs_pkg::FUNC_DELETE, 31'd0);
        send_request(bhs_pkg::FUNC_FIND,   31'd0);
        send_request(bhs_pkg::FUNC_SPARE,  31'h7FFF_FFFF);

        // Random part in idling phases: none, request side idle about half
        // the time, response side stalling about half the time, then both
        // at a lighter rate.
        run_phase(0, 0, PHASE_BEATS);
        run_phase(49, 0, PHASE_BEATS);
        run_phase(0, 49, PHASE_BEATS);
        run_phase(13, 13, PHASE_BEATS);

        // Back-pressure: the response side holds off for a long stretch while
        // request beats keep coming, so the unit fills and stalls its input.
        hold_request = 1'b1;
        run_phase(0, 0, PRESSURE_BEATS);

        req_valid <= 1'b0;

        // Drain every owed response, then give the pipeline time to show any
        // stray beat before the verdict.
        wait (pending == 0);
        repeat (10) @(posedge clk);

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/bhs_pkg.sv
design/bhs_front.sv
design/bhs_queue.sv
design/bhs_back.sv
design/bucketed_hash_set_unit.sv
bench/bucketed_hash_set_checker.sv
bench/bucketed_hash_set_unit_tb.sv
